// ===== design/aba_pkg.sv =====
// Shared types and constants for the arena bump allocator.
// No dependencies; aba_alu, aba_seq, the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package aba_pkg;

    localparam int ADDR_W           = 64;
    localparam int LEN_W            = 32;
    localparam int SIZE_W           = 32;
    localparam int OFS_W            = 33;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int RECORD_SLOTS_DEF = 128;

    // Allocation granule is 8 bytes.
    localparam logic [OFS_W-1:0] ALIGN_MASK = OFS_W'(7);

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_LENGTH = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOCATE = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_CLEAR    = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_ARENA  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_RECORD = 3'd3,
        ST_NOT_LIVE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_WR,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   addr;
    } t_res;

endpackage

`default_nettype wire

// ===== design/aba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/aba_alu.sv =====
// Shared arithmetic unit: one 64-bit adder with a bound compare and an
// equality compare. Used for the fit check, the address sum and the record match.
`timescale 1ns / 1ps
`default_nettype none

module aba_alu (
    input  wire logic [aba_pkg::ADDR_W-1:0] i_a,
    input  wire logic [aba_pkg::ADDR_W-1:0] i_b,
    input  wire logic [aba_pkg::ADDR_W-1:0] i_c,
    output logic      [aba_pkg::ADDR_W:0]   o_sum,
    output logic                            o_sum_le_c,
    output logic                            o_a_eq_c
);
    import aba_pkg::*;

    assign o_sum      = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum_le_c = (o_sum <= {1'b0, i_c});
    assign o_a_eq_c   = (i_a == i_c);

endmodule

`default_nettype wire

// ===== design/aba_seq.sv =====
// Request sequencer: bump pointer, record count and the release scan.
// Depends on aba_pkg, aba_alu; drives the record RAM held by the top level.
`timescale 1ns / 1ps
`default_nettype none

module aba_seq #(
    parameter int RECORD_SLOTS = aba_pkg::RECORD_SLOTS_DEF,
    parameter int IDX_W        = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1,
    parameter int CNT_W        = $clog2(RECORD_SLOTS + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [aba_pkg::OP_W-1:0]        i_op,
    input  wire logic [aba_pkg::SIZE_W-1:0]      i_size,
    input  wire logic [aba_pkg::ADDR_W-1:0]      i_addr,
    input  wire logic [aba_pkg::ADDR_W-1:0]      i_base,
    input  wire logic [aba_pkg::LEN_W-1:0]       i_length,
    output logic                                 o_busy,
    output logic                                 o_done,
    output aba_pkg::t_res                        o_res,
    input  wire logic                            i_take,
    output logic                                 o_ram_we,
    output logic      [IDX_W-1:0]                o_ram_waddr,
    output logic      [aba_pkg::ADDR_W:0]        o_ram_wdata,
    output logic      [IDX_W-1:0]                o_ram_raddr,
    input  wire logic [aba_pkg::ADDR_W:0]        i_ram_rdata
);
    import aba_pkg::*;

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op,    n_op;
    logic [SIZE_W-1:0]  r_size,  n_size;
    logic [ADDR_W-1:0]  r_addr,  n_addr;
    logic [OFS_W-1:0]   r_fill,  n_fill;
    logic [CNT_W-1:0]   r_used,  n_used;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    t_res               r_res,   n_res;

    logic [OFS_W-1:0]   want;
    logic [CNT_W-1:0]   idx_nx;
    logic [ADDR_W-1:0]  alu_a, alu_b, alu_c;
    logic [ADDR_W:0]    alu_sum;
    logic               alu_le, alu_eq;

    aba_alu u_alu (
        .i_a        (alu_a),
        .i_b        (alu_b),
        .i_c        (alu_c),
        .o_sum      (alu_sum),
        .o_sum_le_c (alu_le),
        .o_a_eq_c   (alu_eq)
    );

    assign want   = ({1'b0, r_size} + ALIGN_MASK) & ~ALIGN_MASK;
    assign idx_nx = CNT_W'(r_idx) + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_used  <= n_used;
        end
        r_op   <= n_op;
        r_size <= n_size;
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_fill      = r_fill;
        n_used      = r_used;
        n_idx       = r_idx;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_used[IDX_W-1:0];
        o_ram_wdata = '0;
        o_ram_raddr = '0;
        alu_a       = '0;
        alu_b       = '0;
        alu_c       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_size  = i_size;
                    n_addr  = i_addr;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '{status: ST_OK, addr: '0};
                n_state = S_DONE;
                case (t_op'(r_op))
                    OP_ALLOCATE: begin
                        alu_a = ADDR_W'(r_fill);
                        alu_b = ADDR_W'(want);
                        alu_c = ADDR_W'(i_length);
                        if (i_length == '0) begin
                            n_res.status = ST_NO_ARENA;
                        end else if (!alu_le) begin
                            n_res.status = ST_FULL;
                        end else if (r_used >= CNT_W'(RECORD_SLOTS)) begin
                            n_res.status = ST_NO_RECORD;
                        end else begin
                            n_state = S_ALLOC_WR;
                        end
                    end
                    OP_RELEASE: begin
                        // read of slot 0 is issued here
                        n_idx = '0;
                        if (r_used == '0) begin
                            n_res.status = ST_NOT_LIVE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        n_fill = '0;
                        n_used = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC_WR: begin
                alu_a       = i_base;
                alu_b       = ADDR_W'(r_fill);
                o_ram_we    = 1'b1;
                o_ram_wdata = {1'b1, alu_sum[ADDR_W-1:0]};
                n_res.addr  = alu_sum[ADDR_W-1:0];
                n_used      = r_used + CNT_W'(1);
                n_fill      = r_fill + want;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                alu_a = i_ram_rdata[ADDR_W-1:0];
                alu_c = r_addr;
                if (i_ram_rdata[ADDR_W] && alu_eq) begin
                    // kill the first live match
                    o_ram_we     = 1'b1;
                    o_ram_waddr  = r_idx;
                    o_ram_wdata  = {1'b0, i_ram_rdata[ADDR_W-1:0]};
                    n_res.status = ST_OK;
                    n_state      = S_DONE;
                end else if (idx_nx == r_used) begin
                    n_res.status = ST_NOT_LIVE;
                    n_state      = S_DONE;
                end else begin
                    o_ram_raddr = idx_nx[IDX_W-1:0];
                    n_idx       = idx_nx[IDX_W-1:0];
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== design/arena_bump_allocator.sv =====
// Top level of the arena bump allocator: configuration registers, output
// register, record RAM. Depends on aba_pkg, aba_seq, aba_ram.
`timescale 1ns / 1ps
`default_nettype none

// Bump allocator over one arena set by arena_base / arena_length (config
// index 0 and 1). Requests are taken one at a time; o_in_stall is high while
// a request is in flight. A successful allocate passes through execute, record
// write and done. Clear, the unused op and a failed allocate go from execute
// straight to done. A release scans the record slots from slot 0 until the
// first live match or the record count, one slot per cycle through the record
// RAM's single read port. The next request is accepted only after the result
// is loaded into the output register. A finished request waits while the
// output register holds a stalled result. A result sits in the output
// register while the next request is accepted. Records beyond the current
// count are never read, so the RAM needs no clearing after reset or clear.
module arena_bump_allocator #(
    parameter int RECORD_SLOTS = aba_pkg::RECORD_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [aba_pkg::OP_W-1:0]          i_op,
    input  wire logic [aba_pkg::SIZE_W-1:0]        i_request_size,
    input  wire logic [aba_pkg::ADDR_W-1:0]        i_release_address,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [aba_pkg::STATUS_W-1:0]      o_status,
    output logic      [aba_pkg::ADDR_W-1:0]        o_buffer_address,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [aba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [aba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import aba_pkg::*;

    localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam int CNT_W = $clog2(RECORD_SLOTS + 1);

    logic [ADDR_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_length;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;

    logic                busy, done, take;
    t_res                res;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [ADDR_W:0]     ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ARENA_BASE:   r_base   <= i_cfg_data;
                CFG_ARENA_LENGTH: r_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register frees when empty or drained this cycle
    assign take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (done && take) begin
            r_out_status <= res.status;
            r_out_addr   <= res.addr;
        end
    end

    aba_seq #(
        .RECORD_SLOTS (RECORD_SLOTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_op        (i_op),
        .i_size      (i_request_size),
        .i_addr      (i_release_address),
        .i_base      (r_base),
        .i_length    (r_length),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (res),
        .i_take      (take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    aba_ram #(
        .WIDTH (ADDR_W + 1),
        .DEPTH (RECORD_SLOTS),
        .AW    (IDX_W)
    ) u_records (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall       = busy;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_buffer_address = r_out_addr;

endmodule

`default_nettype wire

// ===== design/aba_checker.sv =====
// Port-level checks for the arena bump allocator, bound to the top level.
// Depends on aba_pkg and arena_bump_allocator.
`timescale 1ns / 1ps
`default_nettype none

module aba_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic [aba_pkg::OP_W-1:0]          i_op,
    input wire logic [aba_pkg::SIZE_W-1:0]        i_request_size,
    input wire logic [aba_pkg::ADDR_W-1:0]        i_release_address,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [aba_pkg::STATUS_W-1:0]      o_status,
    input wire logic [aba_pkg::ADDR_W-1:0]        o_buffer_address,
    input wire logic                              i_cfg_valid,
    input wire logic                              o_cfg_ready,
    input wire logic [aba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input wire logic [aba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import aba_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_buffer_address))
        else $error("result changed while stalled");

    // only a successful allocate carries an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_buffer_address == '0))
        else $error("failed request returned an address");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NO_ARENA
            || o_status == ST_FULL || o_status == ST_NO_RECORD
            || o_status == ST_NOT_LIVE))
        else $error("undefined status code");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind arena_bump_allocator aba_checker u_aba_checker (.*);

`default_nettype wire
